### rtl/sac_pkg.sv
// Shared types and constants for the string atlas cache.
// No dependencies; sac_collect, sac_engine and string_atlas_cache import this package.
`default_nettype none

package sac_pkg;

    localparam int DEF_LINES      = 32;
    localparam int DEF_LINE_CHARS = 64;
    localparam int GLYPH_W        = 6;
    localparam int GLYPH_H        = 12;

    // Length field between the collector and the engine, wide enough for 256 characters.
    localparam int LEN_W = 9;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_LINE_RD,
        S_LINE_CHK,
        S_SEG_RD,
        S_SEG_CHK,
        S_TXT_RD,
        S_TXT_CHK,
        S_PLACE,
        S_COPY_RD,
        S_COPY_WR,
        S_DONE
    } sac_state_t;

    typedef struct packed {
        logic             done;
        logic             cut;
        logic [LEN_W-1:0] len;
    } sac_collect_t;

endpackage

`default_nettype wire

### rtl/sac_if.sv
// Handshake interfaces for the character input and the result output.
// No dependencies.
`default_nettype none

interface sac_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface sac_result_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       evicted;
    logic       truncated;
    logic [4:0] line_index;
    logic [5:0] slot_index;
    logic [5:0] start_column;
    logic [6:0] string_length;
    logic [8:0] pixel_left;
    logic [8:0] pixel_top;

    modport source (output valid, hit, evicted, truncated, line_index, slot_index,
                    start_column, string_length, pixel_left, pixel_top, input ready);
    modport sink   (input valid, hit, evicted, truncated, line_index, slot_index,
                    start_column, string_length, pixel_left, pixel_top, output ready);
endinterface

`default_nettype wire

### rtl/string_atlas_cache.sv
// String atlas cache: characters enter one per cycle while the block is collecting.
// After the last character, the search walks the stored segments until one matches,
// reading the line, segment and text memories, each with a registered read; a miss
// then copies the string character by character into the chosen line.
// The result sits in an output register. Reset clears the collector count, valid bits
// and pointers at once; no clearing pass.
`default_nettype none

module string_atlas_cache
    import sac_pkg::*;
#(
    parameter int LINES      = DEF_LINES,
    parameter int LINE_CHARS = DEF_LINE_CHARS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sac_char_if.sink     chars,
    sac_result_if.source results
);

    localparam int CW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    logic          idle;
    logic [CW-1:0] in_raddr;
    logic [7:0]    in_rdata;
    sac_collect_t  status;

    sac_collect #(.LINE_CHARS(LINE_CHARS), .CW(CW)) u_collect (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .idle   (idle),
        .raddr  (in_raddr),
        .rdata  (in_rdata),
        .status (status)
    );

    sac_engine #(.LINES(LINES), .LINE_CHARS(LINE_CHARS), .CW(CW)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .in_rdata (in_rdata),
        .in_raddr (in_raddr),
        .idle     (idle),
        .results  (results)
    );

endmodule

`default_nettype wire

### rtl/sac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/sac_collect.sv
// Collects the incoming string into a character buffer RAM and tracks length and cut.
// Depends on sac_pkg, sac_if and sac_ram.
`default_nettype none

module sac_collect
    import sac_pkg::*;
#(
    parameter int LINE_CHARS = DEF_LINE_CHARS,
    parameter int CW         = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    sac_char_if.sink             chars,
    input  wire logic            idle,
    input  wire logic [CW-1:0]   raddr,
    output logic      [7:0]      rdata,
    output sac_collect_t         status
);

    localparam logic [LEN_W-1:0] LC = LEN_W'(LINE_CHARS);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             cut_reg, cut_next;
    sac_collect_t     status_reg, status_next;
    logic             accept;
    logic             room;

    assign chars.ready = idle && !status_reg.done;
    assign accept      = chars.valid && chars.ready;
    assign room        = len_reg < LC;
    assign status      = status_reg;

    sac_ram #(.WIDTH(8), .DEPTH(LINE_CHARS), .AW(CW)) u_text (
        .clk   (clk),
        .we    (accept && room),
        .waddr (len_reg[CW-1:0]),
        .wdata (chars.char_code),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        len_next         = len_reg;
        cut_next         = cut_reg;
        status_next      = status_reg;
        status_next.done = 1'b0;
        if (accept)
        begin
            if (room)
            begin
                len_next = len_reg + 1'b1;
            end
            else
            begin
                cut_next = 1'b1;
            end
            if (chars.last_char)
            begin
                // Hand the closed string over and start the next one empty.
                status_next.done = 1'b1;
                status_next.len  = len_next;
                status_next.cut  = cut_next;
                len_next         = '0;
                cut_next         = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            cut_reg    <= 1'b0;
            status_reg <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            cut_reg    <= cut_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sac_engine.sv
// Search and placement sequencer over the line, segment and text memories.
// Depends on sac_pkg, sac_if and sac_ram.
`default_nettype none

module sac_engine
    import sac_pkg::*;
#(
    parameter int LINES      = DEF_LINES,
    parameter int LINE_CHARS = DEF_LINE_CHARS,
    parameter int CW         = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sac_collect_t  status,
    input  wire logic [7:0]    in_rdata,
    output logic      [CW-1:0] in_raddr,
    output logic               idle,
    sac_result_if.source       results
);

    localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int NW    = $clog2(LINE_CHARS + 1);
    localparam int CELLS = LINES * LINE_CHARS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [LW-1:0] LAST_LINE = LW'(LINES - 1);
    localparam logic [AW-1:0] LC_A      = AW'(LINE_CHARS);
    localparam logic [NW:0]   LC_W      = (NW + 1)'(LINE_CHARS);

    sac_state_t state_reg, state_next;

    logic [LW-1:0] j_reg, j_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] start_reg, start_next;
    logic [NW-1:0] len_reg, len_next;
    logic          cut_reg, cut_next;
    logic [NW-1:0] n_reg, n_next;
    logic          hit_reg, hit_next;
    logic          evicted_reg, evicted_next;
    logic          fit_reg, fit_next;
    logic [LW-1:0] fit_line_reg, fit_line_next;
    logic [AW-1:0] fit_base_reg, fit_base_next;
    logic [NW-1:0] fit_segs_reg, fit_segs_next;
    logic [NW-1:0] fit_used_reg, fit_used_next;
    logic [LW-1:0] ep_reg, ep_next;
    logic [AW-1:0] ep_base_reg, ep_base_next;
    logic [LINES-1:0] line_valid_reg, line_valid_next;
    logic          lv_rd_reg;

    // Line info RAM holds {segments, characters used}.
    logic            li_we;
    logic [LW-1:0]   li_waddr;
    logic [2*NW-1:0] li_wdata, li_rdata;
    logic [NW-1:0]   li_segs, li_used;

    // Segment RAM holds {start column, length}.
    logic               seg_we;
    logic [AW-1:0]      seg_waddr, seg_raddr;
    logic [CW+NW-1:0]   seg_wdata, seg_rdata;
    logic [CW-1:0]      seg_start;
    logic [NW-1:0]      seg_len;

    logic          txt_we;
    logic [AW-1:0] txt_waddr, txt_raddr, txt_addr;
    logic [7:0]    txt_rdata;

    logic          out_free;
    logic          out_load;
    logic          out_valid_reg;
    logic          o_hit_reg, o_evicted_reg, o_cut_reg;
    logic [4:0]    o_line_reg;
    logic [5:0]    o_slot_reg, o_start_reg;
    logic [6:0]    o_len_reg;
    logic [8:0]    o_px_reg, o_py_reg;
    logic [15:0]   line_w, slot_w, start_w, len_w, px_w, py_w;

    logic          last_slot, last_char, fits;

    sac_ram #(.WIDTH(2*NW), .DEPTH(LINES), .AW(LW)) u_line (
        .clk(clk), .we(li_we), .waddr(li_waddr), .wdata(li_wdata),
        .raddr(j_reg), .rdata(li_rdata)
    );

    sac_ram #(.WIDTH(CW+NW), .DEPTH(CELLS), .AW(AW)) u_seg (
        .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
        .raddr(seg_raddr), .rdata(seg_rdata)
    );

    sac_ram #(.WIDTH(8), .DEPTH(CELLS), .AW(AW)) u_txt (
        .clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(in_rdata),
        .raddr(txt_raddr), .rdata(txt_rdata)
    );

    // A line never written reads as empty.
    assign li_segs   = lv_rd_reg ? li_rdata[2*NW-1:NW] : '0;
    assign li_used   = lv_rd_reg ? li_rdata[NW-1:0]    : '0;
    assign seg_start = seg_rdata[CW+NW-1:NW];
    assign seg_len   = seg_rdata[NW-1:0];

    assign seg_raddr = base_reg + AW'(i_reg);
    assign txt_addr  = base_reg + AW'(start_reg) + AW'(k_reg);
    assign txt_raddr = txt_addr;
    assign txt_waddr = txt_addr;
    assign in_raddr  = k_reg;

    assign last_slot = ((NW + 1)'(i_reg) + 1'b1) >= {1'b0, n_reg};
    assign last_char = ((NW + 1)'(k_reg) + 1'b1) >= {1'b0, len_reg};
    assign fits      = ((LC_W - {1'b0, li_used}) >= {1'b0, len_reg})
                       && ({1'b0, li_segs} < LC_W);

    assign out_free  = !out_valid_reg || results.ready;
    assign idle      = (state_reg == S_COLLECT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_COLLECT:  if (status.done) state_next = S_LINE_RD;
            S_LINE_RD:  state_next = S_LINE_CHK;
            S_LINE_CHK:
            begin
                if (li_segs != '0)
                    state_next = S_SEG_RD;
                else if (j_reg == LAST_LINE)
                    state_next = S_PLACE;
                else
                    state_next = S_LINE_RD;
            end
            S_SEG_RD:   state_next = S_SEG_CHK;
            S_SEG_CHK:
            begin
                if (seg_len == len_reg)
                    state_next = S_TXT_RD;
                else if (!last_slot)
                    state_next = S_SEG_RD;
                else if (j_reg == LAST_LINE)
                    state_next = S_PLACE;
                else
                    state_next = S_LINE_RD;
            end
            S_TXT_RD:   state_next = S_TXT_CHK;
            S_TXT_CHK:
            begin
                if (txt_rdata == in_rdata)
                    state_next = last_char ? S_DONE : S_TXT_RD;
                else if (!last_slot)
                    state_next = S_SEG_RD;
                else if (j_reg == LAST_LINE)
                    state_next = S_PLACE;
                else
                    state_next = S_LINE_RD;
            end
            S_PLACE:    state_next = S_COPY_RD;
            S_COPY_RD:  state_next = S_COPY_WR;
            S_COPY_WR:  state_next = last_char ? S_DONE : S_COPY_RD;
            S_DONE:     if (out_free) state_next = S_COLLECT;
            default:    state_next = S_COLLECT;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        j_next          = j_reg;
        base_next       = base_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        cut_next        = cut_reg;
        n_next          = n_reg;
        hit_next        = hit_reg;
        evicted_next    = evicted_reg;
        fit_next        = fit_reg;
        fit_line_next   = fit_line_reg;
        fit_base_next   = fit_base_reg;
        fit_segs_next   = fit_segs_reg;
        fit_used_next   = fit_used_reg;
        ep_next         = ep_reg;
        ep_base_next    = ep_base_reg;
        line_valid_next = line_valid_reg;
        li_we           = 1'b0;
        li_waddr        = fit_line_reg;
        li_wdata        = '0;
        seg_we          = 1'b0;
        seg_waddr       = fit_base_reg;
        seg_wdata       = '0;
        txt_we          = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_COLLECT:
            begin
                if (status.done)
                begin
                    len_next     = NW'(status.len);
                    cut_next     = status.cut;
                    j_next       = '0;
                    base_next    = '0;
                    fit_next     = 1'b0;
                    hit_next     = 1'b0;
                    evicted_next = 1'b0;
                end
            end
            S_LINE_CHK:
            begin
                if (fits && !fit_reg)
                begin
                    fit_next      = 1'b1;
                    fit_line_next = j_reg;
                    fit_base_next = base_reg;
                    fit_segs_next = li_segs;
                    fit_used_next = li_used;
                end
                n_next = li_segs;
                i_next = '0;
                if (li_segs == '0 && j_reg != LAST_LINE)
                begin
                    j_next    = j_reg + 1'b1;
                    base_next = base_reg + LC_A;
                end
            end
            S_SEG_CHK, S_TXT_CHK:
            begin
                if (state_reg == S_SEG_CHK && seg_len == len_reg)
                begin
                    start_next = seg_start;
                    k_next     = '0;
                end
                else if (state_reg == S_TXT_CHK && txt_rdata == in_rdata)
                begin
                    if (last_char)
                        hit_next = 1'b1;
                    else
                        k_next = k_reg + 1'b1;
                end
                else if (!last_slot)
                begin
                    i_next = i_reg + 1'b1;
                end
                else if (j_reg != LAST_LINE)
                begin
                    j_next    = j_reg + 1'b1;
                    base_next = base_reg + LC_A;
                end
            end
            S_PLACE:
            begin
                li_we  = 1'b1;
                seg_we = 1'b1;
                k_next = '0;
                if (fit_reg)
                begin
                    j_next     = fit_line_reg;
                    base_next  = fit_base_reg;
                    i_next     = CW'(fit_segs_reg);
                    start_next = CW'(fit_used_reg);
                    li_waddr   = fit_line_reg;
                    li_wdata   = {fit_segs_reg + 1'b1, fit_used_reg + len_reg};
                    seg_waddr  = fit_base_reg + AW'(fit_segs_reg);
                    seg_wdata  = {CW'(fit_used_reg), len_reg};
                    line_valid_next[fit_line_reg] = 1'b1;
                end
                else
                begin
                    // Empty the round-robin line and restart it at column 0.
                    j_next       = ep_reg;
                    base_next    = ep_base_reg;
                    i_next       = '0;
                    start_next   = '0;
                    evicted_next = 1'b1;
                    li_waddr     = ep_reg;
                    li_wdata     = {NW'(1), len_reg};
                    seg_waddr    = ep_base_reg;
                    seg_wdata    = {{CW{1'b0}}, len_reg};
                    line_valid_next[ep_reg] = 1'b1;
                    if (ep_reg == LAST_LINE)
                    begin
                        ep_next      = '0;
                        ep_base_next = '0;
                    end
                    else
                    begin
                        ep_next      = ep_reg + 1'b1;
                        ep_base_next = ep_base_reg + LC_A;
                    end
                end
            end
            S_COPY_WR:
            begin
                txt_we = 1'b1;
                k_next = k_reg + 1'b1;
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign line_w  = 16'(j_reg);
    assign slot_w  = 16'(i_reg);
    assign start_w = 16'(start_reg);
    assign len_w   = 16'(len_reg);
    assign px_w    = start_w * 16'(GLYPH_W);
    assign py_w    = line_w * 16'(GLYPH_H);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_COLLECT;
            ep_reg         <= '0;
            ep_base_reg    <= '0;
            line_valid_reg <= '0;
            lv_rd_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ep_reg         <= ep_next;
            ep_base_reg    <= ep_base_next;
            line_valid_reg <= line_valid_next;
            lv_rd_reg      <= line_valid_reg[j_reg];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        base_reg     <= base_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        start_reg    <= start_next;
        len_reg      <= len_next;
        cut_reg      <= cut_next;
        n_reg        <= n_next;
        hit_reg      <= hit_next;
        evicted_reg  <= evicted_next;
        fit_reg      <= fit_next;
        fit_line_reg <= fit_line_next;
        fit_base_reg <= fit_base_next;
        fit_segs_reg <= fit_segs_next;
        fit_used_reg <= fit_used_next;
        if (out_load)
        begin
            o_hit_reg     <= hit_reg;
            o_evicted_reg <= evicted_reg;
            o_cut_reg     <= cut_reg;
            o_line_reg    <= line_w[4:0];
            o_slot_reg    <= slot_w[5:0];
            o_start_reg   <= start_w[5:0];
            o_len_reg     <= len_w[6:0];
            o_px_reg      <= px_w[8:0];
            o_py_reg      <= py_w[8:0];
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.hit           = o_hit_reg;
    assign results.evicted       = o_evicted_reg;
    assign results.truncated     = o_cut_reg;
    assign results.line_index    = o_line_reg;
    assign results.slot_index    = o_slot_reg;
    assign results.start_column  = o_start_reg;
    assign results.string_length = o_len_reg;
    assign results.pixel_left    = o_px_reg;
    assign results.pixel_top     = o_py_reg;

endmodule

`default_nettype wire
